// File: rtl/fsge_pkg.sv
package fsge_pkg;

   // Grid geometry defaults
   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;
   localparam int ADDR_W_DEF      = $clog2(GRID_WIDTH_DEF) + $clog2(GRID_HEIGHT_DEF);

   // Field widths
   localparam int CELL_W      = 8;
   localparam int PTR_W       = 12;
   localparam int READ_XY_W   = 6;
   localparam int SCALE_W     = 5;
   localparam int DIV_W       = 2 * SCALE_W;
   localparam int SEED_W      = 16;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PAINT = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_PIXELS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANDOM_SEED   = 2'd2;

   // Galois feedback mask of the direction generator (shift right)
   localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_P_RD,
      ST_P_CHK,
      ST_RD_CUR,
      ST_RD_BELOW,
      ST_CHK_BELOW,
      ST_CHK_DIAG,
      ST_MOVE_CLR,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   // Completion reported by the sequencer
   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   kind;
      logic [CELL_W-1:0] value;
   } done_type;

endpackage

// File: rtl/fsge_cell_ram.sv
module fsge_cell_ram #(
   parameter int ADDR_W = fsge_pkg::ADDR_W_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fsge_pkg::CELL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [fsge_pkg::CELL_W-1:0] rd_data
);
   import fsge_pkg::*;

   logic [CELL_W-1:0] mem [2**ADDR_W];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fsge_div.sv
module fsge_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fsge_pkg::PTR_W-1:0] dividend_x,
   input  logic [fsge_pkg::PTR_W-1:0] dividend_y,
   input  logic [fsge_pkg::DIV_W-1:0] divisor,
   output logic                       done,
   output logic [fsge_pkg::PTR_W-1:0] quot_x,
   output logic [fsge_pkg::PTR_W-1:0] quot_y
);
   import fsge_pkg::*;

   localparam int CNT_W = $clog2(PTR_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PTR_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [PTR_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [DIV_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [DIV_W:0]   stage_x, stage_y;

   // One restoring step: returns {quotient bit, new remainder}
   function automatic logic [DIV_W:0] div_stage(input logic [DIV_W-1:0] r,
                                                input logic             b,
                                                input logic [DIV_W-1:0] d);
      logic [DIV_W:0] t;
      logic [DIV_W:0] diff;
      t    = {r, b};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         return {1'b1, diff[DIV_W-1:0]};
      end
      return {1'b0, t[DIV_W-1:0]};
   endfunction

   assign stage_x = div_stage(rx_ff, qx_ff[PTR_W-1], d_ff);
   assign stage_y = div_stage(ry_ff, qy_ff[PTR_W-1], d_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         d_in    = divisor;
         qx_in   = dividend_x;
         qy_in   = dividend_y;
         rx_in   = '0;
         ry_in   = '0;
      end else if (busy_ff) begin
         // shift one dividend bit in, one quotient bit out per cycle
         qx_in  = {qx_ff[PTR_W-2:0], stage_x[DIV_W]};
         qy_in  = {qy_ff[PTR_W-2:0], stage_y[DIV_W]};
         rx_in  = stage_x[DIV_W-1:0];
         ry_in  = stage_y[DIV_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      d_ff   <= d_in;
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
   end

   assign done   = done_ff;
   assign quot_x = qx_ff;
   assign quot_y = qy_ff;

endmodule

// File: rtl/fsge_ctrl.sv
module fsge_ctrl #(
   parameter int GRID_WIDTH  = fsge_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = fsge_pkg::GRID_HEIGHT_DEF,
   parameter int ADDR_W      = fsge_pkg::ADDR_W_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fsge_pkg::OP_W-1:0]      req_op,
   input  logic [fsge_pkg::CELL_W-1:0]    req_paint_value,
   input  logic [fsge_pkg::READ_XY_W-1:0] req_cell_x,
   input  logic [fsge_pkg::READ_XY_W-1:0] req_cell_y,
   output logic                           div_start,
   input  logic                           div_done,
   input  logic [fsge_pkg::PTR_W-1:0]     quot_x,
   input  logic [fsge_pkg::PTR_W-1:0]     quot_y,
   input  logic                           seed_load,
   input  logic [fsge_pkg::SEED_W-1:0]    seed_value,
   input  logic                           out_free,
   output fsge_pkg::done_type             done,
   output logic                           mem_wr_en,
   output logic [ADDR_W-1:0]              mem_wr_addr,
   output logic [fsge_pkg::CELL_W-1:0]    mem_wr_data,
   output logic                           mem_rd_en,
   output logic [ADDR_W-1:0]              mem_rd_addr,
   input  logic [fsge_pkg::CELL_W-1:0]    mem_rd_data
);
   import fsge_pkg::*;

   localparam int XW = $clog2(GRID_WIDTH);
   localparam int YW = $clog2(GRID_HEIGHT);
   localparam int CW = PTR_W + 1;
   localparam logic [CW-1:0] W_C     = CW'(GRID_WIDTH);
   localparam logic [CW-1:0] H_C     = CW'(GRID_HEIGHT);
   localparam logic [XW-1:0] X_LAST  = XW'(GRID_WIDTH - 1);
   localparam logic [YW-1:0] Y_START = YW'(GRID_HEIGHT - 2);

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [CELL_W-1:0] pv_ff, pv_in;
   logic [1:0]        corner_ff, corner_in;
   logic [XW-1:0]     x_ff, x_in, nx_ff, nx_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [CELL_W-1:0] cur_ff, cur_in, value_ff, value_in;
   logic              hit_ff, hit_in;
   logic [SEED_W-1:0] lfsr_ff, lfsr_in, lfsr_step;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic              accept, read_hit, paint_in, paint_rd, last_corner;
   logic              last_cell, adv, go_right;
   logic [CW-1:0]     rx_c, ry_c, px_c, py_c;
   logic [ADDR_W-1:0] paint_addr, read_addr;
   logic [YW-1:0]     y_below;
   logic [XW-1:0]     nx_calc;
   state_type         next_cell;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign rx_c      = CW'(req_cell_x);
   assign ry_c      = CW'(req_cell_y);
   assign read_hit  = (rx_c < W_C) && (ry_c < H_C);
   assign read_addr = {rx_c[XW-1:0], ry_c[YW-1:0]};

   // corners in order: top-left, top-right, bottom-right, bottom-left
   assign px_c        = CW'(quot_x) + CW'(corner_ff == 2'd1 || corner_ff == 2'd2);
   assign py_c        = CW'(quot_y) + CW'(corner_ff[1]);
   assign paint_in    = (px_c < W_C) && (py_c < H_C);
   assign paint_addr  = {px_c[XW-1:0], py_c[YW-1:0]};
   assign paint_rd    = paint_in && (pv_ff != '0);
   assign last_corner = (corner_ff == 2'd3);

   assign y_below   = y_ff + YW'(1);
   assign last_cell = (y_ff == '0) && (x_ff == X_LAST);
   assign next_cell = last_cell ? ST_FINISH : ST_RD_CUR;

   // blocked particle: pick a diagonal, mirror it at the side walls
   assign lfsr_step = {1'b0, lfsr_ff[SEED_W-1:1]} ^ (lfsr_ff[0] ? LFSR_MASK : '0);
   assign go_right  = lfsr_ff[0] ? (x_ff != X_LAST) : (x_ff == '0);
   assign nx_calc   = go_right ? x_ff + XW'(1) : x_ff - XW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_PAINT: state_in = ST_DIV;
                  OP_STEP:  state_in = ST_RD_CUR;
                  OP_READ:  state_in = ST_READ_WAIT;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) state_in = ST_P_RD;
         end
         ST_P_RD: begin
            if (paint_rd) state_in = ST_P_CHK;
            else if (last_corner) state_in = ST_FINISH;
         end
         ST_P_CHK:     state_in = last_corner ? ST_FINISH : ST_P_RD;
         ST_RD_CUR:    state_in = ST_RD_BELOW;
         ST_RD_BELOW:  state_in = (mem_rd_data == '0) ? next_cell : ST_CHK_BELOW;
         ST_CHK_BELOW: state_in = (mem_rd_data == '0) ? ST_MOVE_CLR : ST_CHK_DIAG;
         ST_CHK_DIAG:  state_in = (mem_rd_data == '0) ? ST_MOVE_CLR : next_cell;
         ST_MOVE_CLR:  state_in = next_cell;
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      div_start   = 1'b0;
      adv         = 1'b0;
      op_in       = op_ff;
      pv_in       = pv_ff;
      corner_in   = corner_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      nx_in       = nx_ff;
      cur_in      = cur_ff;
      value_in    = value_ff;
      hit_in      = hit_ff;
      lfsr_in     = lfsr_ff;
      clr_in      = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               pv_in     = req_paint_value;
               corner_in = '0;
               x_in      = '0;
               y_in      = Y_START;
               value_in  = '0;
               hit_in    = read_hit;
               div_start = (req_op == OP_PAINT);
               if (req_op == OP_READ && read_hit) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = read_addr;
               end
            end
         end
         ST_DIV: begin
         end
         ST_P_RD: begin
            if (paint_rd) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = paint_addr;
            end else begin
               // erase writes blindly; out-of-grid corners drop
               mem_wr_en   = paint_in;
               mem_wr_addr = paint_addr;
               corner_in   = corner_ff + 2'd1;
            end
         end
         ST_P_CHK: begin
            mem_wr_en   = (mem_rd_data == '0);
            mem_wr_addr = paint_addr;
            mem_wr_data = pv_ff;
            corner_in   = corner_ff + 2'd1;
         end
         ST_RD_CUR: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = {x_ff, y_ff};
         end
         ST_RD_BELOW: begin
            cur_in = mem_rd_data;
            if (mem_rd_data == '0) begin
               adv = 1'b1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = {x_ff, y_below};
            end
         end
         ST_CHK_BELOW: begin
            if (mem_rd_data == '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = {x_ff, y_below};
               mem_wr_data = cur_ff;
            end else begin
               lfsr_in     = lfsr_step;
               nx_in       = nx_calc;
               mem_rd_en   = 1'b1;
               mem_rd_addr = {nx_calc, y_below};
            end
         end
         ST_CHK_DIAG: begin
            if (mem_rd_data == '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = {nx_ff, y_below};
               mem_wr_data = cur_ff;
            end else begin
               adv = 1'b1;
            end
         end
         ST_MOVE_CLR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = {x_ff, y_ff};
            adv         = 1'b1;
         end
         ST_READ_WAIT: begin
            if (hit_ff) value_in = mem_rd_data;
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
      // scan order: rows bottom to top, then next column
      if (adv) begin
         if (y_ff == '0) begin
            y_in = Y_START;
            x_in = x_ff + XW'(1);
         end else begin
            y_in = y_ff - YW'(1);
         end
      end
      if (seed_load) begin
         lfsr_in = (seed_value == '0) ? SEED_W'(1) : seed_value;
      end
   end

   assign done.valid = (state_ff == ST_FINISH);
   assign done.kind  = op_ff;
   assign done.value = value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         lfsr_ff  <= SEED_W'(1);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         lfsr_ff  <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pv_ff     <= pv_in;
      corner_ff <= corner_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      nx_ff     <= nx_in;
      cur_ff    <= cur_in;
      value_ff  <= value_in;
      hit_ff    <= hit_in;
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("cell memory read and written in one cycle");

   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("direction generator stuck at zero");

   a_scan_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_CUR) |-> (x_ff <= X_LAST && y_ff <= Y_START))
      else $error("step scan left the grid");

   a_div_follows: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_DIV))
      else $error("divider started outside a paint request");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !out_free) |=> (state_ff == ST_FINISH))
      else $error("completion dropped while output register busy");

endmodule

// File: rtl/falling_sand_grid_engine.sv
// Falling-sand grid engine: a GRID_WIDTH x GRID_HEIGHT grid of 8-bit cells
// (0 = empty) held in one block RAM, updated by paint, step and read requests.
// Request channel req_*: operation in req_tuser, other fields in req_tdata.
// Response channel rsp_*: one response per request, the operation echoed in
// rsp_tuser and the read cell (0 for paint and step) in rsp_tdata.
// CSR channel csr_*: always ready; 0 display_scale, 1 cell_pixels,
// 2 random_seed (loads the direction LFSR at once). Write it while idle.
// Sequence from the accepting edge to rsp_tvalid:
//   read: fetch the cell; unused operation: finish directly;
//   paint: the pointer divider, then per 2x2 corner a read and a write if
//         empty (a blind write to erase; out-of-grid corners skip), then finish;
//   step: every cell above the bottom row, through the single read and
//         write port, then finish.
// One request is in flight at a time; the next one is accepted while the
// previous response still sits in the output register.
// Reset: a clearing pass writes zero to all 2**(clog2(W)+clog2(H)) entries
// (4096 at 64x64) before req_tready rises; CSRs return to 1.
// A stalled rsp_tready holds the response; the engine then waits with the
// next result until the output register drains.
module falling_sand_grid_engine #(
   parameter int GRID_WIDTH  = fsge_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = fsge_pkg::GRID_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // CSR write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fsge_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsge_pkg::SEED_W-1:0]      csr_data,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [11:0] pointer_x, [23:12] pointer_y, [31:24] paint_value,
   // [37:32] cell_x, [43:38] cell_y, [47:44] zero
   input  logic [fsge_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] operation
   input  logic [fsge_pkg::OP_W-1:0]        req_tuser,
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] cell_value
   output logic [fsge_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] result_kind
   output logic [fsge_pkg::OP_W-1:0]        rsp_tuser
);
   import fsge_pkg::*;

   localparam int ADDR_W = $clog2(GRID_WIDTH) + $clog2(GRID_HEIGHT);

   // request field unpack
   logic [PTR_W-1:0]     req_pointer_x, req_pointer_y;
   logic [CELL_W-1:0]    req_paint_value;
   logic [READ_XY_W-1:0] req_cell_x, req_cell_y;

   assign req_pointer_x   = req_tdata[11:0];
   assign req_pointer_y   = req_tdata[23:12];
   assign req_paint_value = req_tdata[31:24];
   assign req_cell_x      = req_tdata[37:32];
   assign req_cell_y      = req_tdata[43:38];

   // configuration registers
   logic [SCALE_W-1:0] display_scale_ff, display_scale_in;
   logic [SCALE_W-1:0] cell_pixels_ff, cell_pixels_in;
   logic [SCALE_W-1:0] scale_eff, pixels_eff;
   logic [DIV_W-1:0]   divisor;
   logic               csr_write, seed_load;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign seed_load = csr_write && (csr_index == CSR_RANDOM_SEED);

   always_comb begin
      display_scale_in = display_scale_ff;
      cell_pixels_in   = cell_pixels_ff;
      if (csr_write && csr_index == CSR_DISPLAY_SCALE) begin
         display_scale_in = csr_data[SCALE_W-1:0];
      end
      if (csr_write && csr_index == CSR_CELL_PIXELS) begin
         cell_pixels_in = csr_data[SCALE_W-1:0];
      end
   end

   // a zero divisor acts as one; two truncating divides equal one divide
   // by the product
   assign scale_eff  = (display_scale_ff == '0) ? SCALE_W'(1) : display_scale_ff;
   assign pixels_eff = (cell_pixels_ff == '0) ? SCALE_W'(1) : cell_pixels_ff;
   assign divisor    = DIV_W'(scale_eff) * DIV_W'(pixels_eff);

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic              out_free;
   done_type          done;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      if (done.valid && out_free) begin
         // load the finished response
         rsp_valid_in = 1'b1;
         rsp_kind_in  = done.kind;
         rsp_value_in = done.value;
      end else if (rsp_tready) begin
         // drop the delivered response
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_scale_ff <= SCALE_W'(1);
         cell_pixels_ff   <= SCALE_W'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         display_scale_ff <= display_scale_in;
         cell_pixels_ff   <= cell_pixels_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_value_ff;

   // pointer divider
   logic             div_start, div_done;
   logic [PTR_W-1:0] quot_x, quot_y;

   fsge_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend_x (req_pointer_x),
      .dividend_y (req_pointer_y),
      .divisor    (divisor),
      .done       (div_done),
      .quot_x     (quot_x),
      .quot_y     (quot_y)
   );

   // cell memory
   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [CELL_W-1:0] mem_wr_data, mem_rd_data;

   fsge_cell_ram #(
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer
   fsge_ctrl #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_op          (req_tuser),
      .req_paint_value (req_paint_value),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .div_start       (div_start),
      .div_done        (div_done),
      .quot_x          (quot_x),
      .quot_y          (quot_y),
      .seed_load       (seed_load),
      .seed_value      (csr_data),
      .out_free        (out_free),
      .done            (done),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

endmodule

// File: verif/fsge_checker.sv
`timescale 1ns / 100ps

module fsge_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [fsge_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsge_pkg::SEED_W-1:0]      csr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [fsge_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [fsge_pkg::OP_W-1:0]        req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [fsge_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [fsge_pkg::OP_W-1:0]        rsp_tuser,
   output int                               outstanding,
   output int                               fail_count
);
   import fsge_pkg::*;

   localparam int GW = GRID_WIDTH_DEF;
   localparam int GH = GRID_HEIGHT_DEF;

   typedef struct packed {
      logic [OP_W-1:0]   kind;
      logic [CELL_W-1:0] value;
   } answer_type;

   logic [CELL_W-1:0]  sand_grid [GW*GH];
   logic [SEED_W-1:0]  dir_lfsr;
   logic [SCALE_W-1:0] scale_reg;
   logic [SCALE_W-1:0] pixels_reg;
   answer_type         answers_due [$];
   int                 mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void load_seed(input logic [SEED_W-1:0] seed);
      dir_lfsr = (seed == '0) ? SEED_W'(1) : seed;
   endfunction

   // 0 picks the left diagonal, 1 the right one
   function automatic logic lfsr_draw();
      logic out_bit;
      out_bit  = dir_lfsr[0];
      dir_lfsr = dir_lfsr >> 1;
      if (out_bit)
         dir_lfsr = dir_lfsr ^ LFSR_MASK;
      return out_bit;
   endfunction

   function automatic void put_cell(input int unsigned x, input int unsigned y,
                                    input logic [CELL_W-1:0] v);
      if (x < GW && y < GH) begin
         if (v == '0)
            sand_grid[x*GH + y] = '0;
         else if (sand_grid[x*GH + y] == '0)
            sand_grid[x*GH + y] = v;
      end
   endfunction

   function automatic void paint_block(input int unsigned px, input int unsigned py,
                                       input logic [CELL_W-1:0] v);
      int unsigned ds;
      int unsigned cp;
      int unsigned x;
      int unsigned y;
      ds = (scale_reg == '0) ? 1 : 32'(scale_reg);
      cp = (pixels_reg == '0) ? 1 : 32'(pixels_reg);
      x  = px / ds / cp;
      y  = py / ds / cp;
      put_cell(x, y, v);
      put_cell(x + 1, y, v);
      put_cell(x + 1, y + 1, v);
      put_cell(x, y + 1, v);
   endfunction

   // One in-place pass; the bottom row never moves and never draws a bit.
   function automatic void settle_pass();
      logic [CELL_W-1:0] v;
      int nx;
      for (int x = 0; x < GW; x++) begin
         for (int y = GH - 2; y >= 0; y--) begin
            v = sand_grid[x*GH + y];
            if (v != '0) begin
               if (sand_grid[x*GH + y + 1] == '0) begin
                  sand_grid[x*GH + y + 1] = v;
                  sand_grid[x*GH + y]     = '0;
               end else begin
                  nx = lfsr_draw() ? x + 1 : x - 1;
                  if (nx < 0 || nx >= GW)
                     nx = 2 * x - nx;
                  if (nx >= 0 && nx < GW && sand_grid[nx*GH + y + 1] == '0) begin
                     sand_grid[nx*GH + y + 1] = v;
                     sand_grid[x*GH + y]      = '0;
                  end
               end
            end
         end
      end
   endfunction

   function automatic answer_type predict_answer(input logic [OP_W-1:0] op,
                                                 input logic [REQ_DATA_W-1:0] data);
      answer_type a;
      int cx;
      int cy;
      a.kind  = op;
      a.value = '0;
      cx      = int'(data[37:32]);
      cy      = int'(data[43:38]);
      case (op)
         OP_PAINT: paint_block(32'(data[11:0]), 32'(data[23:12]), data[31:24]);
         OP_STEP:  settle_pass();
         OP_READ: begin
            if (cx < GW && cy < GH)
               a.value = sand_grid[cx*GH + cy];
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int i = 0; i < GW*GH; i++)
            sand_grid[i] = '0;
         scale_reg  = SCALE_W'(1);
         pixels_reg = SCALE_W'(1);
         load_seed(SEED_W'(1));
         answers_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DISPLAY_SCALE: scale_reg  = csr_data[SCALE_W-1:0];
               CSR_CELL_PIXELS:   pixels_reg = csr_data[SCALE_W-1:0];
               CSR_RANDOM_SEED:   load_seed(csr_data);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("response kind %0d value %0d with no request open",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = answers_due.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("result_kind got %0d want %0d",
                                            rsp_tuser, want.kind));
               if (rsp_tdata !== want.value)
                  report_mismatch($sformatf("cell_value got %0d want %0d (kind %0d)",
                                            rsp_tdata, want.value, want.kind));
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(predict_answer(req_tuser, req_tdata));
      end
      outstanding <= answers_due.size();
      fail_count  <= mismatches;
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import fsge_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 15;
   // long receiver hold-off, so the engine fills up and drops req_tready
   localparam int HOLD_CYCLES     = 3000;
   // a full step scans every cell and the clearing pass writes every entry;
   // keep a wide margin
   localparam int IDLE_LIMIT      = 100000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int PTR_MAX         = (1 << PTR_W) - 1;
   localparam int GW              = GRID_WIDTH_DEF;
   localparam int GH              = GRID_HEIGHT_DEF;

   // codes the package leaves unnamed
   localparam logic [OP_W-1:0]        OP_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [SEED_W-1:0]      csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [OP_W-1:0]        rsp_tuser;

   int outstanding;
   int fail_count;
   int phase_no    = 0;
   int burst_left  = 0;
   int unit_px     = 1;   // window pixels per grid cell under the current CSRs
   int last_cx     = 0;   // cell of the latest paint, aimed at by reads
   int last_cy     = 0;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   falling_sand_grid_engine dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   fsge_checker u_sand_check (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // tdata layout: [11:0] pointer_x, [23:12] pointer_y, [31:24] paint_value,
   // [37:32] cell_x, [43:38] cell_y, [47:44] zero
   function automatic logic [REQ_DATA_W-1:0] pack_request(input int px, input int py,
                                                          input int pv, input int cx,
                                                          input int cy);
      return {4'b0, cy[5:0], cx[5:0], pv[7:0], py[11:0], px[11:0]};
   endfunction

   // Offer one request and hold it until accepted. Between bursts, drop valid
   // for a random gap, which may be zero; within a burst valid stays high from request to request.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [REQ_DATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 7))
            0, 1:    gap = 0;
            2:       gap = $urandom_range(20, 60);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tuser  <= op;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic paint_at(input int px, input int py, input int pv);
      send_request(OP_PAINT, pack_request(px, py, pv, $urandom, $urandom));
   endtask

   task automatic read_cell(input int cx, input int cy);
      send_request(OP_READ, pack_request($urandom, $urandom, $urandom, cx, cy));
   endtask

   // unused fields carry noise so every bit toggles
   task automatic request_filler(input logic [OP_W-1:0] op);
      send_request(op, pack_request($urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   // Leave csr_valid high across back-to-back writes; the caller drops it.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [SEED_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain the engine, then rewrite the CSRs. The unused index goes first and
   // must change nothing.
   task automatic set_config(input logic [SEED_W-1:0] scale_word,
                             input logic [SEED_W-1:0] pixels_word,
                             input logic [SEED_W-1:0] seed_word, input bit write_seed);
      int s;
      int p;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_write(CSR_UNUSED, SEED_W'($urandom));
      csr_write(CSR_DISPLAY_SCALE, scale_word);
      csr_write(CSR_CELL_PIXELS, pixels_word);
      if (write_seed)
         csr_write(CSR_RANDOM_SEED, seed_word);
      csr_valid <= 1'b0;
      s       = (scale_word[SCALE_W-1:0] == '0) ? 1 : int'(scale_word[SCALE_W-1:0]);
      p       = (pixels_word[SCALE_W-1:0] == '0) ? 1 : int'(pixels_word[SCALE_W-1:0]);
      unit_px = s * p;
   endtask

   // Divisor with noise above the 5 used bits; favor small pitches so paint
   // still spreads over the grid.
   function automatic logic [SEED_W-1:0] divisor_word();
      logic [SEED_W-1:0] w;
      w = SEED_W'($urandom);
      case ($urandom_range(0, 7))
         0:       w[SCALE_W-1:0] = 5'd0;
         1:       w[SCALE_W-1:0] = 5'd1;
         2:       w[SCALE_W-1:0] = 5'd16;
         3:       w[SCALE_W-1:0] = 5'd31;
         default: w[SCALE_W-1:0] = SCALE_W'($urandom_range(1, 3));
      endcase
      return w;
   endfunction

   // Mostly in-grid paint biased to the lower rows so piles form and
   // particles get blocked; reads aim near the latest paint half the time.
   task automatic send_random_item();
      int r;
      int tmax;
      int tx;
      int ty;
      int px;
      int py;
      int pv;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         tmax = PTR_MAX / unit_px;
         if (tmax > GW - 1)
            tmax = GW - 1;
         tx = $urandom_range(0, tmax);
         if ($urandom_range(0, 1))
            ty = $urandom_range((tmax > 20) ? tmax - 20 : 0, tmax);
         else
            ty = $urandom_range(0, tmax);
         px = tx * unit_px + $urandom_range(0, unit_px - 1);
         py = ty * unit_px + $urandom_range(0, unit_px - 1);
         if (px > PTR_MAX)
            px = PTR_MAX;
         if (py > PTR_MAX)
            py = PTR_MAX;
         if ($urandom_range(0, 7) == 0)
            px = $urandom_range(0, PTR_MAX);
         if ($urandom_range(0, 7) == 0)
            py = $urandom_range(0, PTR_MAX);
         pv = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 255);
         last_cx = tx;
         last_cy = ty;
         paint_at(px, py, pv);
      end else if (r < 80) begin
         if ($urandom_range(0, 1))
            read_cell(last_cx + $urandom_range(0, 1), last_cy + $urandom_range(0, 3));
         else
            read_cell($urandom_range(0, GW - 1),
                      $urandom_range(0, 1) ? $urandom_range(GH - 16, GH - 1)
                                           : $urandom_range(0, GH - 1));
      end else if (r < 92) begin
         request_filler(OP_STEP);
      end else begin
         request_filler(OP_UNUSED);
      end
   endtask

   // Receiver: switch among stall modes at random intervals; once, in the
   // second random phase, hold off for a long stretch while requests pile up.
   initial begin
      int  mode;
      int  mode_left;
      int  tick;
      bit  hold_done;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && phase_no == 2) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            tick++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 9) != 0);
               default: rsp_tready <= ((tick % 7) < 4);
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("falling_sand_grid_engine verification failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // wait out the clearing pass
      do @(posedge clock); while (req_tready !== 1'b1);

      // Directed part under reset CSRs (scale 1, pitch 1, seed 1).
      read_cell(0, 0);                 // empty grid reads zero
      read_cell(GW - 1, GH - 1);
      paint_at(0, 0, 8'hFF);           // top-left block
      paint_at(0, 0, 8'h55);           // occupied cells keep their shade
      read_cell(1, 1);
      paint_at(PTR_MAX, PTR_MAX, 8'h80);   // wholly outside the grid
      paint_at(GW - 1, GH - 1, 8'h01);     // only the corner cell lands
      paint_at(GW - 2, GH - 3, 8'hAA);     // right edge, blocked below: mirror left
      paint_at(30, GH - 4, 8'h07);         // two stacked blocks: diagonal moves
      paint_at(30, GH - 2, 8'h09);         // and re-visits in the next column
      paint_at(0, 0, 8'h00);               // erase the top-left block
      paint_at(0, GH - 2, 8'h3C);          // left edge on the bottom: mirror right
      request_filler(OP_STEP);
      request_filler(OP_STEP);
      read_cell(GW - 1, GH - 1);
      read_cell(31, GH - 1);
      read_cell(32, GH - 1);
      read_cell(0, GH - 2);
      request_filler(OP_UNUSED);
      request_filler(OP_STEP);

      // zero scale acts as 1, pitch at its 5-bit top, zero seed loads 1
      set_config(16'hFFE0, 16'h001F, 16'h0000, 1'b1);
      paint_at(1000, 1000, 8'hC3);
      paint_at(PTR_MAX, PTR_MAX, 8'hFE);
      request_filler(OP_STEP);

      // scale and pitch 16 each (divisor 256) and an all-ones seed
      set_config(16'h0010, 16'h0010, 16'hFFFF, 1'b1);
      paint_at(PTR_MAX, PTR_MAX, 8'h11);
      read_cell(15, 15);
      request_filler(OP_STEP);

      // Random part: fresh CSRs per phase; keep the LFSR running across some.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_config(divisor_word(), divisor_word(),
                    ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom),
                    $urandom_range(0, 3) != 0);
         phase_no <= ph + 1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            send_random_item();
      end

      // Drain: drop valid, wait for every response, then watch for strays.
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("falling_sand_grid_engine verification clean");
      else
         $display("falling_sand_grid_engine verification failed");
      $finish;
   end

endmodule
